// ===== rtl/core/lfga_pkg.sv =====
package lfga_pkg;

    localparam int HistoryDepthDef = 10;
    localparam int CoefWidthDef    = 32;

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_AVG    = 2'd1;
    localparam logic [1:0] ST_ZERO   = 2'd2;

    localparam logic [1:0] REG_ROWS   = 2'd0;
    localparam logic [1:0] REG_MINW   = 2'd1;
    localparam logic [1:0] REG_MAXW   = 2'd2;
    localparam logic [1:0] REG_SPREAD = 2'd3;

    typedef struct packed {
        logic signed [31:0] left_quad;
        logic signed [31:0] left_lin;
        logic signed [31:0] left_const;
        logic signed [31:0] right_quad;
        logic signed [31:0] right_lin;
        logic signed [31:0] right_const;
    } t_in;

    typedef struct packed {
        logic [1:0]         fit_status;
        logic signed [31:0] out_left_quad;
        logic signed [31:0] out_left_lin;
        logic signed [31:0] out_left_const;
        logic signed [31:0] out_right_quad;
        logic signed [31:0] out_right_lin;
        logic signed [31:0] out_right_const;
    } t_out;

    typedef struct packed {
        logic [11:0] min_w;
        logic [11:0] max_w;
        logic [11:0] spread;
    } t_gate_cfg;

endpackage

// ===== rtl/core/lfga_lane.sv =====
// one lane: evaluates x = a*y*y + b*y + c for one fit at one row, through registered products
module lfga_lane import lfga_pkg::*; #(
    parameter int CW = CoefWidthDef
) (
    input  logic                 i_clk,
    input  logic signed [CW-1:0] i_a,
    input  logic signed [CW-1:0] i_b,
    input  logic signed [CW-1:0] i_c,
    input  logic [11:0]          i_y,
    output logic signed [33:0]   o_x
);
    // y*y fits 24 bits; a*yy is the widest product
    logic [23:0]                r_yy;
    logic signed [CW+24:0]      r_ayy;
    logic signed [CW+20:0]      r_by;
    logic signed [CW+27:0]      r_acc;
    logic signed [CW+27:0]      n_acc;
    logic signed [CW+27:0]      n_q;

    always_ff @(posedge i_clk) begin
        r_yy  <= 24'(i_y) * 24'(i_y);
        r_by  <= i_b * $signed({1'b0, i_y}) * $signed(10'sd256);
        r_ayy <= i_a * $signed({1'b0, r_yy});
        r_acc <= n_acc;
    end

    always_comb begin
        n_acc = (CW+28)'(r_ayy) + (CW+28)'(r_by) + ((CW+28)'(i_c) <<< 8);
        n_q = (r_acc < 0) ? -((-r_acc) >>> 24) : (r_acc >>> 24);
    end

    // a steep fit can land just past 32 bits
    assign o_x = 34'(n_q);
endmodule

// ===== rtl/core/lfga_merge.sv =====
// merges the three lane widths into a pass/fail
module lfga_merge import lfga_pkg::*; (
    input  logic               i_clk,
    input  logic signed [33:0] i_xl [3],
    input  logic signed [33:0] i_xr [3],
    input  t_gate_cfg          i_cfg,
    output logic               o_pass
);
    logic signed [34:0] r_w [3];
    logic signed [34:0] n_lo, n_hi;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_w[i] <= 35'(i_xr[i]) - 35'(i_xl[i]);
        end
    end

    always_comb begin
        n_lo = r_w[0];
        n_hi = r_w[0];
        for (int i = 1; i < 3; i++) begin
            if (r_w[i] < n_lo) n_lo = r_w[i];
            if (r_w[i] > n_hi) n_hi = r_w[i];
        end
    end

    assign o_pass = !(36'(n_hi) - 36'(n_lo) > $signed({24'd0, i_cfg.spread}))
                 && !(n_lo < $signed({23'd0, i_cfg.min_w}))
                 && !(n_hi > $signed({23'd0, i_cfg.max_w}));
endmodule

// ===== rtl/core/lfga_div.sv =====
// restoring divider: signed 36-bit sum by unsigned 4-bit count, one bit per cycle
module lfga_div import lfga_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [35:0] i_num,
    input  logic [3:0]         i_den,
    output logic               o_done,
    output logic signed [35:0] o_quo
);
    logic [35:0] r_q;
    logic [4:0]  r_rem;
    logic [5:0]  r_cnt;
    logic        r_neg, r_busy, r_done;
    logic [3:0]  r_den;
    logic [4:0]  n_sh;

    assign n_sh = {r_rem[3:0], r_q[35]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_neg  <= i_num[35];
                r_q    <= i_num[35] ? 36'(-i_num) : i_num;
                r_rem  <= 5'd0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (n_sh >= {1'b0, r_den}) begin
                    r_rem <= n_sh - {1'b0, r_den};
                    r_q   <= {r_q[34:0], 1'b1};
                end else begin
                    r_rem <= n_sh;
                    r_q   <= {r_q[34:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd35) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

// ===== rtl/core/lane_fit_gate_and_average_unit.sv =====
// an accepted fit runs the evaluation wait, update and output states; a rejected fit with
// empty history gets a second gate pass on zero coefficients; otherwise the average is computed
// (six serial divisions, then a second gate pass)
// one item at a time: the next input can be taken in the cycle after the result is registered
// reset (i_rst_n low, synchronous): config registers to defaults, state idle, output valid low,
// sums and fill count zero, history pointer to last slot; history memory is not cleared
module lane_fit_gate_and_average_unit import lfga_pkg::*; #(
    parameter int HISTORY_DEPTH = HistoryDepthDef,
    parameter int COEF_WIDTH    = CoefWidthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data
);
    localparam int PW = $clog2(HISTORY_DEPTH + 1);
    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = COEF_WIDTH;

    localparam logic [3:0] S_IDLE = 4'd0, S_EVAL = 4'd1, S_WAIT = 4'd2, S_UPD = 4'd3,
                           S_DIV = 4'd4, S_DWAIT = 4'd5, S_OUT = 4'd6;

    logic [11:0] r_rows, r_minw, r_maxw, r_spread;
    logic [3:0]  r_st;
    logic [3:0]  r_cnt;
    logic        r_avg;
    logic [1:0]  r_stat;
    logic signed [CW-1:0] r_f [6];
    logic signed [35:0]   r_sum [6];
    logic [PW-1:0] r_fill;
    logic [AW-1:0] r_wp;
    logic [2:0]    r_di;
    logic [6*CW-1:0] r_hist [HISTORY_DEPTH];
    logic [6*CW-1:0] r_old;
    logic          r_ovalid;
    t_out          r_out;

    logic [11:0] n_y [3];
    logic signed [33:0] n_xl [3], n_xr [3];
    logic n_pass;
    logic [AW-1:0] n_p;
    logic n_dstart, n_ddone;
    logic signed [35:0] n_quo;
    logic [6*CW-1:0] n_hw;
    t_gate_cfg n_gcfg;

    assign n_y[0] = r_rows;
    // rows*4/5 by reciprocal multiply, exact for 14-bit values
    assign n_y[1] = 12'(({18'd0, r_rows, 2'b00} * 32'd52429) >> 18);
    assign n_y[2] = {1'b0, r_rows[11:1]};
    assign n_p = (32'(r_wp) == HISTORY_DEPTH - 1) ? '0 : r_wp + AW'(1);
    assign n_gcfg = '{min_w: r_minw, max_w: r_maxw, spread: r_spread};

    for (genvar g = 0; g < 3; g++) begin : g_lane
        lfga_lane #(.CW(CW)) u_l (.i_clk, .i_a(r_f[0]),
            .i_b(r_f[1]), .i_c(r_f[2]), .i_y(n_y[g]), .o_x(n_xl[g]));
        lfga_lane #(.CW(CW)) u_r (.i_clk, .i_a(r_f[3]),
            .i_b(r_f[4]), .i_c(r_f[5]), .i_y(n_y[g]), .o_x(n_xr[g]));
    end

    lfga_merge u_merge (.i_clk, .i_xl(n_xl), .i_xr(n_xr), .i_cfg(n_gcfg), .o_pass(n_pass));

    assign n_dstart = (r_st == S_DIV);
    lfga_div u_div (.i_clk, .i_rst_n, .i_start(n_dstart), .i_num(r_sum[r_di]),
        .i_den(4'(r_fill)), .o_done(n_ddone), .o_quo(n_quo));

    always_comb begin
        for (int k = 0; k < 6; k++) n_hw[k*CW +: CW] = r_f[k];
    end

    // history memory, one slot of six coefficients per word, reads registered
    always_ff @(posedge i_clk) begin
        r_old <= r_hist[n_p];
        if (r_st == S_UPD && !r_avg && n_pass) begin
            r_hist[n_p] <= n_hw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 12'd720; r_minw <= 12'd200; r_maxw <= 12'd975; r_spread <= 12'd350;
            r_st <= S_IDLE;
            r_fill <= '0;
            r_wp <= AW'(HISTORY_DEPTH - 1);
            r_ovalid <= 1'b0;
            for (int k = 0; k < 6; k++) r_sum[k] <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ROWS:   r_rows   <= i_cfg_data;
                    REG_MINW:   r_minw   <= i_cfg_data;
                    REG_MAXW:   r_maxw   <= i_cfg_data;
                    REG_SPREAD: r_spread <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && !i_stall && r_st != S_OUT) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_f[0] <= CW'(i_data.left_quad);
                        r_f[1] <= CW'(i_data.left_lin);
                        r_f[2] <= CW'(i_data.left_const);
                        r_f[3] <= CW'(i_data.right_quad);
                        r_f[4] <= CW'(i_data.right_lin);
                        r_f[5] <= CW'(i_data.right_const);
                        r_avg <= 1'b0;
                        r_cnt <= '0;
                        r_st  <= S_WAIT;
                    end
                end
                S_EVAL: begin
                    r_cnt <= '0;
                    r_st  <= S_WAIT;
                end
                S_WAIT: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd6) r_st <= S_UPD;
                end
                S_UPD: begin
                    if (!r_avg && n_pass) begin
                        for (int k = 0; k < 6; k++) begin
                            r_sum[k] <= r_sum[k] + 36'(r_f[k])
                                - ((32'(r_fill) >= HISTORY_DEPTH)
                                   ? 36'($signed(r_old[k*CW +: CW])) : 36'd0);
                        end
                        if (32'(r_fill) < HISTORY_DEPTH) r_fill <= r_fill + PW'(1);
                        r_wp <= n_p;
                        r_stat <= ST_ACCEPT;
                        r_st <= S_OUT;
                    end else if (!r_avg) begin
                        r_avg <= 1'b1;
                        r_di  <= '0;
                        if (r_fill == '0) begin
                            for (int k = 0; k < 6; k++) r_f[k] <= '0;
                            r_st <= S_EVAL;
                        end else begin
                            r_st <= S_DIV;
                        end
                    end else begin
                        r_stat <= n_pass ? ST_AVG : ST_ZERO;
                        if (!n_pass) for (int k = 0; k < 6; k++) r_f[k] <= '0;
                        r_st <= S_OUT;
                    end
                end
                S_DIV: r_st <= S_DWAIT;
                S_DWAIT: begin
                    if (n_ddone) begin
                        r_f[r_di] <= CW'(n_quo);
                        if (r_di == 3'd5) begin
                            r_st <= S_EVAL;
                        end else begin
                            r_di <= r_di + 3'd1;
                            r_st <= S_DIV;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_out.fit_status      <= r_stat;
                        r_out.out_left_quad   <= 32'(r_f[0]);
                        r_out.out_left_lin    <= 32'(r_f[1]);
                        r_out.out_left_const  <= 32'(r_f[2]);
                        r_out.out_right_quad  <= 32'(r_f[3]);
                        r_out.out_right_lin   <= 32'(r_f[4]);
                        r_out.out_right_const <= 32'(r_f[5]);
                        r_ovalid <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_st != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;
endmodule

// ===== rtl/core/lfga_checker.sv =====
module lfga_checker import lfga_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("output dropped");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.fit_status != 2'd3) else $error("bad status");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.fit_status == ST_ZERO |-> o_data.out_left_quad == 0
        && o_data.out_right_const == 0) else $error("zeros not zero");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("took two items");
endmodule

bind lane_fit_gate_and_average_unit lfga_checker u_chk (.i_clk, .i_rst_n, .i_valid,
    .o_stall, .o_valid, .i_stall, .o_data);
